/* design/tbd_pkg.sv */
package tbd_pkg;

	localparam int SUBBLOCK_BYTES = 256;
	localparam int HEADER_BYTES   = 21;
	localparam int CHK_INDEX      = HEADER_BYTES - 1;

	localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
	localparam int SUB_POS_W = $clog2(SUBBLOCK_BYTES + 1);
	localparam int COUNT_W   = 9;
	localparam int WORD_W    = 16;

	// header field positions, little-endian
	localparam logic [HDR_IDX_W-1:0] ADDR_LO_INDEX = HDR_IDX_W'(16);
	localparam logic [HDR_IDX_W-1:0] ADDR_HI_INDEX = HDR_IDX_W'(17);
	localparam logic [HDR_IDX_W-1:0] SIZE_LO_INDEX = HDR_IDX_W'(18);
	localparam logic [HDR_IDX_W-1:0] SIZE_HI_INDEX = HDR_IDX_W'(19);

	localparam logic [7:0] BAD_FILL = 8'h69;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2,
		PH_CHECK  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_IGNORE    = 3'd0,
		KIND_HEADER    = 3'd1,
		KIND_HDR_CHECK = 3'd2,
		KIND_DATA      = 3'd3,
		KIND_SUB_CHECK = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       byte_bad;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		kind_t               item_kind;
		logic [7:0]          out_byte;
		logic [WORD_W-1:0]   data_offset;
		logic [WORD_W-1:0]   load_address;
		logic [WORD_W-1:0]   data_size;
		logic                check_ok;
		logic                range_ok;
		logic [COUNT_W-1:0]  subblocks_seen;
		logic [COUNT_W-1:0]  subblocks_good;
		logic [WORD_W-1:0]   read_errors;
		logic                frame_end;
	} out_item_t;

endpackage

/* design/tbd_if.sv */
interface tbd_in_if;
	logic               valid;
	logic               ready;
	tbd_pkg::in_item_t  payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tbd_out_if;
	logic               valid;
	logic               ready;
	tbd_pkg::out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* design/tape_block_deframer_xor_check.sv */
// each accepted request's result is registered in the output register
// throughput: one byte per cycle; a new byte is taken whenever the output register
// is empty or being emptied in the same cycle
// reset: arst_n clears the parser to idle, all counters and held header fields to
// zero, and empties the output register
module tape_block_deframer_xor_check (
	input  logic       clk,
	input  logic       arst_n,
	tbd_in_if.sink     din,
	tbd_out_if.source  dout
);

	tbd_pkg::phase_t                     phase_q;
	logic [tbd_pkg::HDR_IDX_W-1:0]       hidx_q;
	logic [7:0]                          rxor_q;
	logic                                sbad_q;
	logic [tbd_pkg::WORD_W-1:0]          load_q;
	logic [tbd_pkg::WORD_W-1:0]          size_q;
	logic [tbd_pkg::WORD_W-1:0]          done_q;
	logic [tbd_pkg::SUB_POS_W-1:0]       spos_q;
	logic [tbd_pkg::COUNT_W-1:0]         seen_q;
	logic [tbd_pkg::COUNT_W-1:0]         good_q;
	logic [tbd_pkg::WORD_W-1:0]          err_q;

	tbd_pkg::phase_t                     phase_n;
	logic [tbd_pkg::HDR_IDX_W-1:0]       hidx_n;
	logic [7:0]                          rxor_n;
	logic                                sbad_n;
	logic [tbd_pkg::WORD_W-1:0]          load_n;
	logic [tbd_pkg::WORD_W-1:0]          size_n;
	logic [tbd_pkg::WORD_W-1:0]          done_n;
	logic [tbd_pkg::SUB_POS_W-1:0]       spos_n;
	logic [tbd_pkg::COUNT_W-1:0]         seen_n;
	logic [tbd_pkg::COUNT_W-1:0]         good_n;
	logic [tbd_pkg::WORD_W-1:0]          err_n;

	tbd_pkg::out_item_t                  res;
	tbd_pkg::out_item_t                  res_q;
	logic                                res_valid_q;
	logic                                accept;

	assign din.ready    = !res_valid_q || dout.ready;
	assign accept       = din.valid && din.ready;
	assign dout.valid   = res_valid_q;
	assign dout.payload = res_q;

	always_comb begin
		logic [7:0]  b;
		logic        bad;
		logic [7:0]  raw;
		logic        chk;
		logic [16:0] last_addr;

		raw = din.payload.byte_value;
		bad = din.payload.byte_bad;
		b   = bad ? tbd_pkg::BAD_FILL : raw;

		// a frame start restarts everything and takes the byte as header byte 0
		if (din.payload.frame_start) begin
			phase_n = tbd_pkg::PH_HEADER;
			hidx_n  = '0;
			rxor_n  = '0;
			sbad_n  = 1'b0;
			load_n  = '0;
			size_n  = '0;
			done_n  = '0;
			spos_n  = '0;
			seen_n  = '0;
			good_n  = '0;
			err_n   = '0;
		end else begin
			phase_n = phase_q;
			hidx_n  = hidx_q;
			rxor_n  = rxor_q;
			sbad_n  = sbad_q;
			load_n  = load_q;
			size_n  = size_q;
			done_n  = done_q;
			spos_n  = spos_q;
			seen_n  = seen_q;
			good_n  = good_q;
			err_n   = err_q;
		end

		chk       = (!sbad_n && !bad && rxor_n == raw);
		last_addr = {1'b0, load_n} + {1'b0, size_n};

		res.item_kind   = tbd_pkg::KIND_IGNORE;
		res.out_byte    = '0;
		res.data_offset = '0;
		res.check_ok    = 1'b0;
		res.range_ok    = 1'b0;
		res.frame_end   = 1'b0;

		case (phase_n)
			tbd_pkg::PH_HEADER: begin
				res.out_byte = b;
				if (hidx_n < tbd_pkg::HDR_IDX_W'(tbd_pkg::CHK_INDEX)) begin
					res.item_kind = tbd_pkg::KIND_HEADER;
					rxor_n = rxor_n ^ b;
					if (bad)
						sbad_n = 1'b1;
					case (hidx_n)
						tbd_pkg::ADDR_LO_INDEX: load_n[7:0]  = b;
						tbd_pkg::ADDR_HI_INDEX: load_n[15:8] = b;
						tbd_pkg::SIZE_LO_INDEX: size_n[7:0]  = b;
						tbd_pkg::SIZE_HI_INDEX: size_n[15:8] = b;
						default: ;
					endcase
					hidx_n = hidx_n + 1'b1;
				end else begin
					res.item_kind = tbd_pkg::KIND_HDR_CHECK;
					res.check_ok  = chk;
					res.range_ok  = (last_addr <= 17'h10000);
					rxor_n = '0;
					sbad_n = 1'b0;
					done_n = '0;
					spos_n = '0;
					if (size_n == '0) begin
						res.frame_end = 1'b1;
						phase_n = tbd_pkg::PH_IDLE;
					end else begin
						phase_n = tbd_pkg::PH_DATA;
					end
				end
			end
			tbd_pkg::PH_DATA: begin
				res.item_kind   = tbd_pkg::KIND_DATA;
				res.out_byte    = b;
				res.data_offset = done_n;
				rxor_n = rxor_n ^ b;
				if (bad) begin
					sbad_n = 1'b1;
					if (err_n != '1)
						err_n = err_n + 1'b1;
				end
				done_n = done_n + 1'b1;
				spos_n = spos_n + 1'b1;
				if (spos_n >= tbd_pkg::SUB_POS_W'(tbd_pkg::SUBBLOCK_BYTES) || done_n == size_n)
					phase_n = tbd_pkg::PH_CHECK;
			end
			tbd_pkg::PH_CHECK: begin
				res.item_kind = tbd_pkg::KIND_SUB_CHECK;
				res.out_byte  = b;
				res.check_ok  = chk;
				if (seen_n != '1)
					seen_n = seen_n + 1'b1;
				if (chk && good_n != '1)
					good_n = good_n + 1'b1;
				rxor_n = '0;
				sbad_n = 1'b0;
				spos_n = '0;
				if (done_n == size_n) begin
					res.frame_end = 1'b1;
					phase_n = tbd_pkg::PH_IDLE;
				end else begin
					phase_n = tbd_pkg::PH_DATA;
				end
			end
			default: ;
		endcase

		res.load_address   = load_n;
		res.data_size      = size_n;
		res.subblocks_seen = seen_n;
		res.subblocks_good = good_n;
		res.read_errors    = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tbd_pkg::PH_IDLE;
			hidx_q  <= '0;
			rxor_q  <= '0;
			sbad_q  <= 1'b0;
			load_q  <= '0;
			size_q  <= '0;
			done_q  <= '0;
			spos_q  <= '0;
			seen_q  <= '0;
			good_q  <= '0;
			err_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				hidx_q  <= hidx_n;
				rxor_q  <= rxor_n;
				sbad_q  <= sbad_n;
				load_q  <= load_n;
				size_q  <= size_n;
				done_q  <= done_n;
				spos_q  <= spos_n;
				seen_q  <= seen_n;
				good_q  <= good_n;
				err_q   <= err_n;
				res_valid_q <= 1'b1;
			end else if (dout.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

endmodule

/* design/tbd_checker.sv */
module tbd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input tbd_pkg::out_item_t out_payload
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed while stalled");

	a_check_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.check_ok |->
			out_payload.item_kind == tbd_pkg::KIND_HDR_CHECK ||
			out_payload.item_kind == tbd_pkg::KIND_SUB_CHECK)
		else $error("check_ok on a non-checkbyte item");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.frame_end |->
			out_payload.item_kind == tbd_pkg::KIND_HDR_CHECK ||
			out_payload.item_kind == tbd_pkg::KIND_SUB_CHECK)
		else $error("frame ended on a non-checkbyte item");

	a_good_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload.subblocks_good <= out_payload.subblocks_seen)
		else $error("more good sub-blocks than seen");

endmodule

bind tape_block_deframer_xor_check tbd_checker u_tbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_payload (dout.payload)
);

/* bench/tape_block_deframer_xor_check_tb.sv */
module tape_block_deframer_xor_check_tb;

	localparam int BYTE_TARGET  = 1850;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_CAP    = 25;

	class deframer_scoreboard;
		tbd_pkg::phase_t                      phase;
		logic [tbd_pkg::HDR_IDX_W-1:0]        hdr_index;
		logic [7:0]                           span_xor;
		logic                                 span_bad;
		logic [tbd_pkg::WORD_W-1:0]           load_addr;
		logic [tbd_pkg::WORD_W-1:0]           size_bytes;
		logic [tbd_pkg::WORD_W-1:0]           bytes_done;
		logic [tbd_pkg::SUB_POS_W-1:0]        sub_pos;
		logic [tbd_pkg::COUNT_W-1:0]          seen_count;
		logic [tbd_pkg::COUNT_W-1:0]          good_count;
		logic [tbd_pkg::WORD_W-1:0]           error_count;
		tbd_pkg::out_item_t                   expected_q[$];
		int mismatches;
		int results;
		int frames;
		int framed_bytes;
		int ignored;
		int hdr_checks;
		int sub_checks;
		int sub_good;

		function new();
			clear_frame();
		endfunction

		function void clear_frame();
			phase       = tbd_pkg::PH_IDLE;
			hdr_index   = '0;
			span_xor    = '0;
			span_bad    = 1'b0;
			load_addr   = '0;
			size_bytes  = '0;
			bytes_done  = '0;
			sub_pos     = '0;
			seen_count  = '0;
			good_count  = '0;
			error_count = '0;
		endfunction

		function void note_request(tbd_pkg::in_item_t req);
			tbd_pkg::out_item_t r;
			logic [7:0]         b;
			r = '0;
			b = req.byte_bad ? tbd_pkg::BAD_FILL : req.byte_value;
			if (req.frame_start) begin
				clear_frame();
				phase = tbd_pkg::PH_HEADER;
				frames++;
			end
			case (phase)
				tbd_pkg::PH_HEADER: begin
					r.out_byte = b;
					if (hdr_index < tbd_pkg::CHK_INDEX) begin
						r.item_kind = tbd_pkg::KIND_HEADER;
						span_xor ^= b;
						if (req.byte_bad)
							span_bad = 1'b1;
						case (hdr_index)
							tbd_pkg::ADDR_LO_INDEX: load_addr[7:0]   = b;
							tbd_pkg::ADDR_HI_INDEX: load_addr[15:8]  = b;
							tbd_pkg::SIZE_LO_INDEX: size_bytes[7:0]  = b;
							tbd_pkg::SIZE_HI_INDEX: size_bytes[15:8] = b;
							default: ;
						endcase
						hdr_index++;
					end else begin
						r.item_kind = tbd_pkg::KIND_HDR_CHECK;
						r.check_ok  = !span_bad && !req.byte_bad && span_xor == req.byte_value;
						r.range_ok  = ({1'b0, load_addr} + {1'b0, size_bytes}) <= 17'h10000;
						hdr_checks++;
						span_xor   = '0;
						span_bad   = 1'b0;
						bytes_done = '0;
						sub_pos    = '0;
						if (size_bytes == '0) begin
							r.frame_end = 1'b1;
							phase = tbd_pkg::PH_IDLE;
						end else begin
							phase = tbd_pkg::PH_DATA;
						end
					end
				end
				tbd_pkg::PH_DATA: begin
					r.item_kind   = tbd_pkg::KIND_DATA;
					r.out_byte    = b;
					r.data_offset = bytes_done;
					span_xor ^= b;
					if (req.byte_bad) begin
						span_bad = 1'b1;
						if (error_count != '1)
							error_count++;
					end
					bytes_done++;
					sub_pos++;
					if (sub_pos >= tbd_pkg::SUBBLOCK_BYTES || bytes_done == size_bytes)
						phase = tbd_pkg::PH_CHECK;
				end
				tbd_pkg::PH_CHECK: begin
					r.item_kind = tbd_pkg::KIND_SUB_CHECK;
					r.out_byte  = b;
					r.check_ok  = !span_bad && !req.byte_bad && span_xor == req.byte_value;
					sub_checks++;
					if (r.check_ok)
						sub_good++;
					if (seen_count != '1)
						seen_count++;
					if (r.check_ok && good_count != '1)
						good_count++;
					span_xor = '0;
					span_bad = 1'b0;
					sub_pos  = '0;
					if (bytes_done == size_bytes) begin
						r.frame_end = 1'b1;
						phase = tbd_pkg::PH_IDLE;
					end else begin
						phase = tbd_pkg::PH_DATA;
					end
				end
				default: ;
			endcase
			r.load_address   = load_addr;
			r.data_size      = size_bytes;
			r.subblocks_seen = seen_count;
			r.subblocks_good = good_count;
			r.read_errors    = error_count;
			if (r.item_kind == tbd_pkg::KIND_IGNORE)
				ignored++;
			else
				framed_bytes++;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, logic [tbd_pkg::WORD_W-1:0] got,
				logic [tbd_pkg::WORD_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
					results, name, got, want));
		endtask

		task check_result(tbd_pkg::out_item_t got);
			tbd_pkg::out_item_t want;
			results++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request pending", results));
				return;
			end
			want = expected_q.pop_front();
			compare_field("item_kind", got.item_kind, want.item_kind);
			compare_field("out_byte", got.out_byte, want.out_byte);
			compare_field("data_offset", got.data_offset, want.data_offset);
			compare_field("load_address", got.load_address, want.load_address);
			compare_field("data_size", got.data_size, want.data_size);
			compare_field("check_ok", got.check_ok, want.check_ok);
			compare_field("range_ok", got.range_ok, want.range_ok);
			compare_field("subblocks_seen", got.subblocks_seen, want.subblocks_seen);
			compare_field("subblocks_good", got.subblocks_good, want.subblocks_good);
			compare_field("read_errors", got.read_errors, want.read_errors);
			compare_field("frame_end", got.frame_end, want.frame_end);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	int   cycles;

	tbd_in_if  in_ch();
	tbd_out_if out_ch();

	deframer_scoreboard sb = new();

	tape_block_deframer_xor_check uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic byte_fault(int pct);
		return $urandom_range(99) < pct;
	endfunction

	task automatic push_byte(input logic [7:0] value, input logic bad, input logic start);
		tbd_pkg::in_item_t req;
		int                gap;
		req.byte_value  = value;
		req.byte_bad    = bad;
		req.frame_start = start;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid   <= 1'b0;
			in_ch.payload <= tbd_pkg::in_item_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= req;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(req);
	endtask

	// checkbyte, either intact, flagged unreadable or with one bit flipped
	task automatic push_checkbyte(input logic [7:0] value, input int fault_pct);
		logic bad;
		bad = byte_fault(fault_pct);
		if (bad && $urandom_range(1)) begin
			bad = 1'b0;
			value ^= 8'h01 << $urandom_range(7);
		end
		push_byte(value, bad, 1'b0);
	endtask

	// one frame, cut short after stop_after requests unless that is negative
	task automatic send_frame(input logic [15:0] load, input logic [15:0] size,
			input int stop_after, input int fault_pct);
		logic [7:0] hdr [tbd_pkg::HEADER_BYTES];
		logic [7:0] v;
		logic [7:0] acc;
		logic       bad;
		int         sent;
		int         left;
		int         chunk;
		sent = 0;
		acc  = 8'h00;
		for (int i = 0; i < tbd_pkg::CHK_INDEX; i++)
			hdr[i] = 8'($urandom);
		hdr[tbd_pkg::ADDR_LO_INDEX] = load[7:0];
		hdr[tbd_pkg::ADDR_HI_INDEX] = load[15:8];
		hdr[tbd_pkg::SIZE_LO_INDEX] = size[7:0];
		hdr[tbd_pkg::SIZE_HI_INDEX] = size[15:8];
		for (int i = 0; i < tbd_pkg::CHK_INDEX; i++)
			acc ^= hdr[i];
		for (int i = 0; i < tbd_pkg::CHK_INDEX; i++) begin
			if (sent == stop_after)
				return;
			push_byte(hdr[i], byte_fault(fault_pct), i == 0);
			sent++;
		end
		if (sent == stop_after)
			return;
		push_checkbyte(acc, fault_pct);
		sent++;
		left = int'(size);
		while (left > 0) begin
			chunk = (left > tbd_pkg::SUBBLOCK_BYTES) ? tbd_pkg::SUBBLOCK_BYTES : left;
			left -= chunk;
			acc = 8'h00;
			repeat (chunk) begin
				if (sent == stop_after)
					return;
				v   = 8'($urandom);
				bad = byte_fault(fault_pct);
				push_byte(v, bad, 1'b0);
				acc ^= bad ? tbd_pkg::BAD_FILL : v;
				sent++;
			end
			if (sent == stop_after)
				return;
			push_checkbyte(acc, fault_pct);
			sent++;
		end
	endtask

	initial begin : result_side
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.payload);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out after %0d cycles", cycles);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  v;
		logic [7:0]  acc;
		logic [15:0] load;
		logic [15:0] size;
		int          pick;
		int          fault_pct;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		arst_n        = 1'b0;
		calm          = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes outside a frame are ignored
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);

		// zero-size header with an unreadable load address byte, so it ends at its checkbyte
		acc = 8'h00;
		for (int i = 0; i < tbd_pkg::CHK_INDEX; i++) begin
			v = (i >= tbd_pkg::SIZE_LO_INDEX) ? 8'h00 : (i[0] ? 8'hFF : 8'h00);
			push_byte(v, i == tbd_pkg::ADDR_LO_INDEX, i == 0);
			acc ^= (i == tbd_pkg::ADDR_LO_INDEX) ? tbd_pkg::BAD_FILL : v;
		end
		push_byte(acc, 1'b0, 1'b0);

		while (sb.framed_bytes < BYTE_TARGET) begin
			calm      = ($urandom_range(7) == 0);
			pick      = $urandom_range(99);
			fault_pct = ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0;
			if (pick < 40) begin
				size = 16'($urandom_range(1, 40));
			end else if (pick < 55) begin
				case ($urandom_range(5))
					0: size = 16'd255;
					1: size = 16'd256;
					2: size = 16'd257;
					3: size = 16'd511;
					4: size = 16'd512;
					default: size = 16'd513;
				endcase
			end else if (pick < 62) begin
				size = 16'd0;
			end else if (pick < 75) begin
				size = 16'($urandom_range(41, 700));
			end else begin
				size = 16'($urandom);
			end
			// last address right at the top, one past it, or anywhere
			case ($urandom_range(3))
				0: load = 16'h0000 - size;
				1: load = 16'h0001 - size;
				default: load = 16'($urandom);
			endcase
			if (pick < 75)
				send_frame(load, size, -1, fault_pct);
			else if (pick < 90)
				send_frame(load, size, $urandom_range(1, 300), fault_pct);
			else
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
		end
		in_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d frame starts: %0d parsed, %0d ignored outside a frame",
			sb.framed_bytes + sb.ignored, sb.frames, sb.framed_bytes, sb.ignored);
		$display("%0d header checkbytes, %0d sub-block checkbytes (%0d matched), %0d mismatches",
			sb.hdr_checks, sb.sub_checks, sb.sub_good, sb.mismatches);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
design/tbd_pkg.sv
design/tbd_if.sv
design/tape_block_deframer_xor_check.sv
design/tbd_checker.sv
bench/tape_block_deframer_xor_check_tb.sv
